### hw/rtl/s15x_pkg.sv
// Shared types, constants and channel arithmetic for the 1.5x interpolating scaler.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package s15x_pkg;

	localparam int LINE_WIDTH_W = 11;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;
	localparam int QCNT_W       = 3;

	typedef enum logic {
		REG_PIXEL_FORMAT = 1'b0,
		REG_LINE_WIDTH   = 1'b1
	} reg_index_t;

	typedef enum logic {
		FMT_RGB565 = 1'b0,
		FMT_RGB555 = 1'b1
	} pixel_format_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        first_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [15:0] top_left;
		logic [15:0] top_mid;
		logic [15:0] top_right;
		logic [15:0] mid_left;
		logic [15:0] center;
		logic [15:0] mid_right;
		logic [15:0] bottom_left;
		logic [15:0] bottom_mid;
		logic [15:0] bottom_right;
	} out_item_t;

	// One 2x2 source block
	typedef struct packed {
		logic [15:0] ul;
		logic [15:0] ur;
		logic [15:0] ll;
		logic [15:0] lr;
	} quad_t;

	typedef struct packed {
		logic  valid;
		quad_t quad;
	} push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} queue_status_t;

	function automatic logic [5:0] chan_r(input logic [15:0] p, input pixel_format_t fmt);
		return (fmt == FMT_RGB555) ? {1'b0, p[14:10]} : {1'b0, p[15:11]};
	endfunction

	function automatic logic [5:0] chan_g(input logic [15:0] p, input pixel_format_t fmt);
		return (fmt == FMT_RGB555) ? {1'b0, p[9:5]} : p[10:5];
	endfunction

	function automatic logic [15:0] pack_rgb(input logic [5:0] r, input logic [5:0] g,
			input logic [4:0] b, input pixel_format_t fmt);
		return (fmt == FMT_RGB555) ? {1'b0, r[4:0], g[4:0], b} : {r[4:0], g, b};
	endfunction

	function automatic logic [15:0] avg2(input logic [15:0] a, input logic [15:0] b,
			input pixel_format_t fmt);
		logic [6:0] rs;
		logic [6:0] gs;
		logic [5:0] bs;
		rs = {1'b0, chan_r(a, fmt)} + {1'b0, chan_r(b, fmt)};
		gs = {1'b0, chan_g(a, fmt)} + {1'b0, chan_g(b, fmt)};
		bs = {1'b0, a[4:0]} + {1'b0, b[4:0]};
		return pack_rgb(rs[6:1], gs[6:1], bs[5:1], fmt);
	endfunction

	function automatic logic [15:0] avg4(input quad_t q, input pixel_format_t fmt);
		logic [7:0] rs;
		logic [7:0] gs;
		logic [6:0] bs;
		rs = {2'b0, chan_r(q.ul, fmt)} + {2'b0, chan_r(q.ur, fmt)}
			+ {2'b0, chan_r(q.ll, fmt)} + {2'b0, chan_r(q.lr, fmt)};
		gs = {2'b0, chan_g(q.ul, fmt)} + {2'b0, chan_g(q.ur, fmt)}
			+ {2'b0, chan_g(q.ll, fmt)} + {2'b0, chan_g(q.lr, fmt)};
		bs = {2'b0, q.ul[4:0]} + {2'b0, q.ur[4:0]} + {2'b0, q.ll[4:0]} + {2'b0, q.lr[4:0]};
		return pack_rgb(rs[7:2], gs[7:2], bs[6:2], fmt);
	endfunction

endpackage

### hw/rtl/scale_1p5x_interpolating_top.sv
// 1.5x interpolating scaler for 16-bit RGB565/RGB555 pixels: each 2x2 source block
// becomes a 3x3 output block (copied corners, floor-averaged edges and center).
// Source pixels enter on in_valid/in_stall (in_data.pixel, in_data.first_of_frame)
// in raster order; first_of_frame restarts the row and column count at that pixel.
// Even rows fill the upper line store; on odd rows every second pixel completes a
// block, which leaves as one item on out_valid/out_stall.
// Registers (cfg_valid/cfg_ready, always ready): index 0 pixel_format, 1 line_width.
// Write them only while no pixel is in flight.
// Throughput: one pixel per clock while in_stall is low. A completed block passes
// through the line store read, the queue and the result register before it leaves.
// When the receiver stalls, the result holds and the 4-entry block queue fills;
// in_stall rises once the queue plus the block being read would fill it.
// Reset clears position, row parity, held pixel, queue and output valid; the line
// store is not cleared and is defined once the even row above has been written.
`timescale 1ns / 1ps

module scale_1p5x_interpolating_top
	import s15x_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_item_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  reg_index_t              cfg_index,
	input  logic [LINE_WIDTH_W-1:0] cfg_data
);

	pixel_format_t           fmt_q;
	logic [LINE_WIDTH_W-1:0] line_width_q;
	push_t                   push;
	logic                    pop;
	quad_t                   head;
	queue_status_t           q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= FMT_RGB565;
			line_width_q <= LINE_WIDTH_W'(320);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: fmt_q <= pixel_format_t'(cfg_data[0]);
				REG_LINE_WIDTH:   line_width_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	s15x_front #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.line_width(line_width_q),
		.q_stat    (q_stat),
		.push      (push)
	);

	s15x_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.q_stat(q_stat)
	);

	s15x_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.fmt      (fmt_q),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

### hw/rtl/s15x_front.sv
// Front end: row/column tracking, upper line store and block assembly.
// Depends on s15x_pkg; pushes complete 2x2 blocks into s15x_queue.
`timescale 1ns / 1ps

module s15x_front
	import s15x_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_data,
	input  logic [LINE_WIDTH_W-1:0] line_width,
	input  queue_status_t           q_stat,
	output push_t                   push
);

	localparam int COL_W      = $clog2(MAX_LINE_WIDTH);
	localparam int WW         = (COL_W + 1 > LINE_WIDTH_W) ? COL_W + 1 : LINE_WIDTH_W + 1;
	localparam int LINE_PAIRS = (MAX_LINE_WIDTH + 1) / 2;
	localparam int AW         = (LINE_PAIRS > 1) ? $clog2(LINE_PAIRS) : 1;

	logic [COL_W-1:0] col_q;
	logic             odd_q;
	logic [15:0]      held_q;

	logic             emit_s1;
	logic [15:0]      ll_s1;
	logic [15:0]      lr_s1;
	logic [31:0]      rd_s1;

	logic [31:0]      line_mem [LINE_PAIRS];

	logic [WW-1:0]    lw_ext;
	logic [WW-1:0]    eff;
	logic [WW-1:0]    eff_even;
	logic [COL_W-1:0] last_col;
	logic [COL_W-1:0] col;
	logic             odd;
	logic             end_row;
	logic [AW-1:0]    addr;
	logic             accept;
	logic             emit;

	// Effective width: clamp to 2..MAX, then round down to even
	always_comb begin
		lw_ext = WW'(line_width);
		priority if (lw_ext < WW'(2)) begin
			eff = WW'(2);
		end else if (lw_ext > WW'(MAX_LINE_WIDTH)) begin
			eff = WW'(MAX_LINE_WIDTH);
		end else begin
			eff = lw_ext;
		end
		eff_even = eff & ~WW'(1);
		if (eff_even < WW'(2)) begin
			eff_even = WW'(2);
		end
		last_col = COL_W'(eff_even - WW'(1));
	end

	always_comb begin
		col = in_data.first_of_frame ? '0 : col_q;
		odd = in_data.first_of_frame ? 1'b0 : odd_q;
		if (col > last_col) begin
			col = last_col;
		end
		end_row = (col >= last_col);
		addr    = AW'(col >> 1);
	end

	assign in_stall = ({1'b0, q_stat.count} + (QCNT_W + 1)'(emit_s1))
		>= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept   = in_valid && !in_stall;
	assign emit     = accept && odd && col[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			odd_q   <= 1'b0;
			held_q  <= '0;
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= emit;
			if (accept) begin
				col_q <= end_row ? '0 : col + COL_W'(1);
				odd_q <= end_row ? !odd : odd;
				if (odd && !col[0]) begin
					held_q <= in_data.pixel;
				end
			end
		end
	end

	// Block payload; valid only qualifies it
	always_ff @(posedge clk) begin
		if (emit) begin
			ll_s1 <= held_q;
			lr_s1 <= in_data.pixel;
		end
	end

	// Line store: one entry per column pair, one lane per column
	always_ff @(posedge clk) begin
		if (accept && !odd) begin
			if (col[0]) begin
				line_mem[addr][31:16] <= in_data.pixel;
			end else begin
				line_mem[addr][15:0] <= in_data.pixel;
			end
		end
		if (emit) begin
			rd_s1 <= line_mem[addr];
		end
	end

	always_comb begin
		push.valid   = emit_s1;
		push.quad.ul = rd_s1[15:0];
		push.quad.ur = rd_s1[31:16];
		push.quad.ll = ll_s1;
		push.quad.lr = lr_s1;
	end

endmodule

### hw/rtl/s15x_queue.sv
// Short block queue between the front end and the interpolation back end.
// Depends on s15x_pkg.
`timescale 1ns / 1ps

module s15x_queue
	import s15x_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	input  logic          pop,
	output quad_t         head,
	output queue_status_t q_stat
);

	quad_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.valid) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.quad;
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.count = count_q;

endmodule

### hw/rtl/s15x_back.sv
// Back end: interpolates one 2x2 block into a 3x3 result and holds it for transfer.
// Depends on s15x_pkg; pops blocks from s15x_queue.
`timescale 1ns / 1ps

module s15x_back
	import s15x_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_stat,
	input  quad_t         head,
	input  pixel_format_t fmt,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output out_item_t     out_data
);

	logic      out_valid_q;
	out_item_t out_data_q;
	out_item_t res;

	assign pop = (q_stat.count != '0) && (!out_valid_q || !out_stall);

	always_comb begin
		res.top_left     = head.ul;
		res.top_mid      = avg2(head.ul, head.ur, fmt);
		res.top_right    = head.ur;
		res.mid_left     = avg2(head.ul, head.ll, fmt);
		res.center       = avg4(head, fmt);
		res.mid_right    = avg2(head.ur, head.lr, fmt);
		res.bottom_left  = head.ll;
		res.bottom_mid   = avg2(head.ll, head.lr, fmt);
		res.bottom_right = head.lr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result while stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
